### design/utf8gc_pkg.sv
`default_nettype none
package utf8gc_pkg;

	localparam int CODE_BITS = 21;

	typedef logic [CODE_BITS-1:0] code_t;
	typedef logic [1:0]           pending_t;

	// Outcome of one byte through the UTF-8 decoder
	typedef struct packed {
		logic     code_valid;
		code_t    code;
		code_t    partial_next;
		pending_t pending_next;
	} dec_result_t;

	localparam code_t CP_ZWJ        = 21'h0200D;
	localparam code_t CP_RI_LO      = 21'h1F1E6;
	localparam code_t CP_RI_HI      = 21'h1F1FF;
	localparam code_t CP_SKIN_LO    = 21'h1F3FB;
	localparam code_t CP_SKIN_HI    = 21'h1F3FF;
	localparam code_t CP_VS_TEXT    = 21'h0FE0E;
	localparam code_t CP_VS_EMOJI   = 21'h0FE0F;
	localparam code_t CP_CM_LO      = 21'h00300;
	localparam code_t CP_CM_HI      = 21'h0036F;
	localparam code_t CP_CM_EXT_LO  = 21'h01AB0;
	localparam code_t CP_CM_EXT_HI  = 21'h01AFF;
	localparam code_t CP_CM_SUP_LO  = 21'h01DC0;
	localparam code_t CP_CM_SUP_HI  = 21'h01DFF;
	localparam code_t CP_CM_SYM_LO  = 21'h020D0;
	localparam code_t CP_CM_SYM_HI  = 21'h020FF;
	localparam code_t CP_CM_HALF_LO = 21'h0FE20;
	localparam code_t CP_CM_HALF_HI = 21'h0FE2F;

	function automatic logic is_regional(input code_t c);
		return (c >= CP_RI_LO) && (c <= CP_RI_HI);
	endfunction

	// Code points that always extend the current cluster
	function automatic logic joins_alone(input code_t c);
		return ((c >= CP_SKIN_LO) && (c <= CP_SKIN_HI)) ||
			(c == CP_VS_TEXT) || (c == CP_VS_EMOJI) ||
			((c >= CP_CM_LO) && (c <= CP_CM_HI)) ||
			((c >= CP_CM_EXT_LO) && (c <= CP_CM_EXT_HI)) ||
			((c >= CP_CM_SUP_LO) && (c <= CP_CM_SUP_HI)) ||
			((c >= CP_CM_SYM_LO) && (c <= CP_CM_SYM_HI)) ||
			((c >= CP_CM_HALF_LO) && (c <= CP_CM_HALF_HI));
	endfunction

endpackage
`default_nettype wire

### design/utf8gc_decode.sv
`default_nettype none
module utf8gc_decode
	import utf8gc_pkg::*;
(
	input  wire logic [7:0]  data_byte,
	input  wire code_t       partial,
	input  wire pending_t    pending,
	output dec_result_t      dec
);

	code_t shifted;

	// Append six payload bits of a following byte
	assign shifted = {partial[CODE_BITS-7:0], data_byte[5:0]};

	always_comb begin
		dec.code_valid   = 1'b0;
		dec.code         = '0;
		dec.partial_next = partial;
		dec.pending_next = pending;
		if (pending != 2'd0) begin
			// Following byte: taken unchecked, lead bytes included
			dec.partial_next = shifted;
			dec.pending_next = pending - 2'd1;
			dec.code_valid   = (pending == 2'd1);
			dec.code         = shifted;
		end else begin
			case (data_byte) inside
				[8'h00:8'h7F]: begin
					dec.code_valid = 1'b1;
					dec.code       = {13'd0, data_byte};
				end
				[8'hC0:8'hDF]: begin
					dec.partial_next = {16'd0, data_byte[4:0]};
					dec.pending_next = 2'd1;
				end
				[8'hE0:8'hEF]: begin
					dec.partial_next = {17'd0, data_byte[3:0]};
					dec.pending_next = 2'd2;
				end
				[8'hF0:8'hF7]: begin
					dec.partial_next = {18'd0, data_byte[2:0]};
					dec.pending_next = 2'd3;
				end
				default: begin
					// Bad lead byte stands for code point zero
					dec.code_valid = 1'b1;
					dec.code       = '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### design/utf8_grapheme_counter.sv
// Grapheme cluster counter over a UTF-8 byte stream.
// A count enters the result register when the last-flagged item leaves the input register.
// Throughput: one byte per cycle outside the input stall described below.
// Input stalls only while a last-flagged item waits behind a count that is not yet taken.
// Reset (arst_n low) clears the decoder, previous code point, count and all valid flags.
`default_nettype none
module utf8_grapheme_counter
	import utf8gc_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_string,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      cluster_count
);

	logic                  valid_s1;
	logic [7:0]            byte_s1;
	logic                  eos_s1;
	logic                  advance;

	code_t                 partial_q;
	pending_t              pending_q;
	code_t                 prev_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  out_valid_q;
	logic [15:0]           count_out_q;

	dec_result_t           dec;
	code_t                 prev_next;
	logic [COUNT_BITS-1:0] count_next;
	logic                  do_count;
	logic [31:0]           count_wide;

	// Hold a last-flagged item only while the result register is full and not being taken
	assign advance  = valid_s1 && (!eos_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			eos_s1  <= end_of_string;
		end
	end

	utf8gc_decode u_decode (
		.data_byte (byte_s1),
		.partial   (partial_q),
		.pending   (pending_q),
		.dec       (dec)
	);

	// Apply the cluster rules to a finished code point
	always_comb begin
		prev_next = prev_q;
		do_count  = 1'b0;
		if (dec.code_valid) begin
			prev_next = dec.code;
			if ((prev_q != '0) && (prev_q == CP_ZWJ)) begin
				do_count = 1'b0;
			end else if ((prev_q != '0) && is_regional(prev_q) && is_regional(dec.code)) begin
				prev_next = '0;
			end else if (!joins_alone(dec.code)) begin
				do_count = 1'b1;
			end
		end
	end

	// Saturating count
	assign count_next = (do_count && (count_q != '1)) ? count_q + 1'b1 : count_q;
	assign count_wide = 32'(count_next);

	// Advance decoder and rule state; clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pending_q <= '0;
			prev_q    <= '0;
			count_q   <= '0;
		end else if (advance) begin
			if (eos_s1) begin
				partial_q <= '0;
				pending_q <= '0;
				prev_q    <= '0;
				count_q   <= '0;
			end else begin
				partial_q <= dec.partial_next;
				pending_q <= dec.pending_next;
				prev_q    <= prev_next;
				count_q   <= count_next;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && eos_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eos_s1) begin
			count_out_q <= count_wide[15:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign cluster_count = count_out_q;

	// A new result appears only from a last-flagged item
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(advance && eos_s1))
		else $error("result without a last-flagged item");

	// State is clear after the end of a string
	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && eos_s1) |=> (pending_q == '0 && prev_q == '0 && count_q == '0))
		else $error("state not cleared after end of string");

	// Only a blocked last-flagged item stalls the input register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |-> (eos_s1 && out_valid_q && !out_ready))
		else $error("input stalled without cause");

	// Within a string the count never falls
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !eos_s1) |=> (count_q >= $past(count_q)))
		else $error("cluster count decreased");

endmodule
`default_nettype wire

### test/utf8_grapheme_counter_tb.sv
// Scoreboard: tracks the cluster rules byte by byte and keeps the counts still owed
class cluster_board;
	localparam logic [20:0] ZWJ     = 21'h0200D;
	localparam logic [20:0] FLAG_LO = 21'h1F1E6;
	localparam logic [20:0] FLAG_HI = 21'h1F1FF;
	localparam logic [15:0] CAP     = 16'hFFFF;

	logic [20:0] gathered;
	logic [1:0]  still_due;
	logic [20:0] kept_code;
	logic [15:0] tally;
	logic [15:0] due_counts[$];
	int unsigned failures;
	int unsigned counts_checked;
	int unsigned top_count;

	function new();
		clear();
		failures = 0;
		counts_checked = 0;
		top_count = 0;
	endfunction

	function void clear();
		gathered = '0;
		still_due = '0;
		kept_code = '0;
		tally = '0;
	endfunction

	function bit in_span(logic [20:0] c, logic [20:0] lo, logic [20:0] hi);
		return c >= lo && c <= hi;
	endfunction

	function bit is_flag(logic [20:0] c);
		return in_span(c, FLAG_LO, FLAG_HI);
	endfunction

	// Modifiers, variation selectors and combining marks never open a cluster
	function bit extends_cluster(logic [20:0] c);
		return in_span(c, 21'h1F3FB, 21'h1F3FF) || c == 21'h0FE0E || c == 21'h0FE0F ||
			in_span(c, 21'h00300, 21'h0036F) || in_span(c, 21'h01AB0, 21'h01AFF) ||
			in_span(c, 21'h01DC0, 21'h01DFF) || in_span(c, 21'h020D0, 21'h020FF) ||
			in_span(c, 21'h0FE20, 21'h0FE2F);
	endfunction

	// Apply one decoded code point to the running cluster count
	function void absorb_code(logic [20:0] c);
		if (kept_code == ZWJ) begin
			kept_code = c;
			return;
		end
		if (is_flag(kept_code) && is_flag(c)) begin
			kept_code = '0;
			return;
		end
		if (!extends_cluster(c) && tally != CAP)
			tally++;
		kept_code = c;
	endfunction

	// Note an accepted input item
	function void note_byte(logic [7:0] b, logic last);
		if (still_due != 0) begin
			gathered = {gathered[14:0], b[5:0]};
			still_due--;
			if (still_due == 0)
				absorb_code(gathered);
		end else if (!b[7]) begin
			absorb_code({13'b0, b});
		end else if (b[7:5] == 3'b110) begin
			gathered = {16'b0, b[4:0]};
			still_due = 2'd1;
		end else if (b[7:4] == 4'b1110) begin
			gathered = {17'b0, b[3:0]};
			still_due = 2'd2;
		end else if (b[7:3] == 5'b11110) begin
			gathered = {18'b0, b[2:0]};
			still_due = 2'd3;
		end else begin
			absorb_code('0);
		end
		if (last) begin
			due_counts.push_back(tally);
			clear();
		end
	endfunction

	// Compare an accepted result with the oldest count owed
	function void check_count(logic [15:0] actual);
		logic [15:0] want;
		if (due_counts.size() == 0) begin
			$error("cluster_count: unexpected item, expected none, actual %0d", actual);
			failures++;
			return;
		end
		want = due_counts.pop_front();
		counts_checked++;
		if (actual > top_count)
			top_count = actual;
		if (actual !== want) begin
			$error("cluster_count: expected %0d, actual %0d", want, actual);
			failures++;
		end
	endfunction

	function int unsigned waiting();
		return due_counts.size();
	endfunction
endclass

module utf8_grapheme_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_RHYTHM} rx_mode_t;

	localparam int unsigned CYCLE_LIMIT  = 1_000_000;
	localparam int unsigned RANDOM_BYTES = 1850;
	localparam int unsigned HOLD_CYCLES  = 300;

	// Code points just outside the borders of the joining, flag and ZWJ ranges
	localparam logic [20:0] RIM_CODES [18] = '{
		21'h002FF, 21'h00370, 21'h01AAF, 21'h01B00, 21'h01DBF, 21'h01E00,
		21'h020CF, 21'h02100, 21'h0FE1F, 21'h0FE30, 21'h0FE0D, 21'h0FE10,
		21'h1F1E5, 21'h1F200, 21'h1F3FA, 21'h1F400, 21'h0200C, 21'h0200E
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  data_byte = 8'h00;
	logic        end_of_string = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] cluster_count;

	cluster_board board = new();

	logic [7:0]  text[$];
	bit          gaps_on = 1'b1;
	int unsigned burst_left = 0;
	int unsigned bytes_sent = 0;
	int unsigned strings_sent = 0;
	int unsigned cycle_count = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_done = 0;
	int unsigned hold_left = 0;
	int unsigned mode_left = 0;
	int unsigned beat = 0;
	int unsigned rhythm = 2;
	rx_mode_t    rx_mode = RX_OPEN;

	utf8_grapheme_counter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.end_of_string(end_of_string),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cluster_count(cluster_count)
	);

	always #1 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("utf8_grapheme_counter_tb: FAIL");
			$finish;
		end
	end

	// Watch both handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_byte(data_byte, end_of_string);
			if (out_valid && out_ready)
				board.check_count(cluster_count);
		end
	end

	// Receiver: long hold-offs on request, otherwise a changing stall pattern
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (holds_done != holds_asked) begin
			holds_done++;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 2));
				mode_left = $urandom_range(32, 256);
				rhythm = $urandom_range(2, 8);
			end
			mode_left--;
			beat++;
			case (rx_mode)
				RX_OPEN: out_ready <= 1'b1;
				RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
				default: out_ready <= (beat % rhythm == 0);
			endcase
		end
	end

	// Offer one item, idling between bursts, and hold it until taken
	task automatic offer_byte(input logic [7:0] b, input logic last);
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		end_of_string <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (burst_left != 0)
			burst_left--;
		bytes_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < text.size(); i++)
			offer_byte(text[i], i == text.size() - 1);
		strings_sent++;
	endtask

	// Stop offering until every count owed has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.waiting() != 0) @(posedge clk);
	endtask

	// Append a code point in UTF-8, now and then in a longer form than needed
	function automatic void add_code(logic [20:0] cp);
		int unsigned len;
		len = cp < 21'h80 ? 1 : cp < 21'h800 ? 2 : cp < 21'h10000 ? 3 : 4;
		if (len < 4 && $urandom_range(0, 9) == 0)
			len = $urandom_range(len + 1, 4);
		case (len)
			1: text.push_back(cp[7:0]);
			2: begin
				text.push_back({3'b110, cp[10:6]});
				text.push_back({2'b10, cp[5:0]});
			end
			3: begin
				text.push_back({4'b1110, cp[15:12]});
				text.push_back({2'b10, cp[11:6]});
				text.push_back({2'b10, cp[5:0]});
			end
			default: begin
				text.push_back({5'b11110, cp[20:18]});
				text.push_back({2'b10, cp[17:12]});
				text.push_back({2'b10, cp[11:6]});
				text.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	// Draw a code point, weighted toward the ones that steer the cluster rules
	function automatic logic [20:0] pick_code();
		case ($urandom_range(0, 19))
			0, 1, 2, 3, 4: return 21'($urandom_range(0, 127));
			5:  return 21'($urandom_range(21'h80, 21'h7FF));
			6:  return 21'($urandom_range(21'h800, 21'hFFFF));
			7:  return 21'($urandom_range(21'h10000, 21'h1FFFFF));
			8, 9: return 21'h0200D;
			10, 11: return 21'($urandom_range(21'h1F1E6, 21'h1F1FF));
			12: return 21'($urandom_range(21'h1F3FB, 21'h1F3FF));
			13: return 21'($urandom_range(21'h0FE0E, 21'h0FE0F));
			14: return 21'($urandom_range(21'h00300, 21'h0036F));
			15: return 21'($urandom_range(21'h01AB0, 21'h01AFF));
			16: return 21'($urandom_range(21'h01DC0, 21'h01DFF));
			17: return 21'($urandom_range(21'h020D0, 21'h020FF));
			18: return 21'($urandom_range(21'h0FE20, 21'h0FE2F));
			default: return RIM_CODES[$urandom_range(0, 17)];
		endcase
	endfunction

	// Well-formed text, sometimes cut off inside a final sequence
	task automatic build_clean();
		int unsigned n;
		text.delete();
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
		repeat (n) add_code(pick_code());
		if ($urandom_range(0, 9) == 0) begin
			text.push_back({4'b1110, 4'($urandom_range(0, 15))});
			if ($urandom_range(0, 1) == 1)
				text.push_back({2'b10, 6'($urandom_range(0, 63))});
		end
	endtask

	// Broken text: stray followers, bad leads, leads out of place
	task automatic build_noise();
		text.delete();
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 3))
				0: text.push_back(8'($urandom_range(0, 255)));
				1: text.push_back(8'($urandom_range(8'h80, 8'hBF)));
				2: text.push_back(8'($urandom_range(8'hC0, 8'hF7)));
				default: text.push_back(8'($urandom_range(8'hF8, 8'hFF)));
			endcase
		end
	endtask

	initial begin
		int unsigned random_start;
		bit held;
		bit paused;
		held = 1'b0;
		paused = 1'b0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: zero byte, bad lead, lone mark, ZWJ join, flag pair,
		// lead in a follower slot, cut-off sequence
		text = '{8'h00};                          send_text();
		text = '{8'hFF};                          send_text();
		text = '{8'hCC, 8'h80};                   send_text();
		text = '{8'h61, 8'hE2, 8'h80, 8'h8D, 8'h62}; send_text();
		text = '{8'hF0, 8'h9F, 8'h87, 8'hA6, 8'hF0, 8'h9F, 8'h87, 8'hA7};
		send_text();
		text = '{8'hE2, 8'hC3, 8'h80};            send_text();
		text = '{8'hF0, 8'h9F};                   send_text();
		drain();

		// Random text with one long receiver hold-off and one full drain
		random_start = bytes_sent;
		while (bytes_sent - random_start < RANDOM_BYTES) begin
			if (!held && bytes_sent - random_start > RANDOM_BYTES / 3) begin
				held = 1'b1;
				gaps_on = 1'b0;
				holds_asked++;
				repeat (60) begin
					text.delete();
					repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(32, 126)));
					send_text();
				end
			end
			if (!paused && bytes_sent - random_start > 2 * RANDOM_BYTES / 3) begin
				paused = 1'b1;
				drain();
			end
			if ($urandom_range(0, 29) == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			if ($urandom_range(0, 4) == 0)
				build_noise();
			else
				build_clean();
			send_text();
		end
		drain();
		repeat (6) @(posedge clk);

		$display("utf8_grapheme_counter_tb: %0d strings, %0d bytes, %0d counts checked",
			strings_sent, bytes_sent, board.counts_checked);
		$display("utf8_grapheme_counter_tb: joins, flags, marks, bad and cut input, top count %0d",
			board.top_count);
		if (board.failures == 0)
			$display("utf8_grapheme_counter_tb: PASS");
		else
			$display("utf8_grapheme_counter_tb: FAIL");
		$finish;
	end
endmodule

### utf8_grapheme_counter.f
design/utf8gc_pkg.sv
design/utf8gc_decode.sv
design/utf8_grapheme_counter.sv
test/utf8_grapheme_counter_tb.sv
